### hdl/dts_pkg.sv
// dts_pkg: shared types, widths and codes for the directional tile select core
// used by dts_rank, the channel interfaces and directional_tile_select_core
`default_nettype none

package dts_pkg;

	// field widths
	localparam int unsigned KEY_W   = 64;
	localparam int unsigned TILE_W  = 17;
	localparam int unsigned COORD_W = 32;
	localparam int unsigned DIR_W   = 2;
	localparam int unsigned FWD_W   = 33;
	localparam int unsigned ACR_W   = 33;
	localparam int unsigned CTR_W   = 34;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_W  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_H  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd4;

	// search directions: bit 1 picks the y axis, bit 0 the positive side
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

	// tile index reported when nothing was chosen (-1)
	localparam logic [TILE_W-1:0] TILE_NONE = '1;

	// source rectangle and direction
	typedef struct packed {
		logic [COORD_W-1:0] source_x;
		logic [COORD_W-1:0] source_y;
		logic [COORD_W-1:0] source_w;
		logic [COORD_W-1:0] source_h;
		logic [DIR_W-1:0]   direction;
	} src_cfg_t;

	// one candidate as held in the input register
	typedef struct packed {
		logic [KEY_W-1:0]   view_key;
		logic [TILE_W-1:0]  tile_number;
		logic [COORD_W-1:0] view_w;
		logic [COORD_W-1:0] view_h;
		logic [COORD_W-1:0] tile_x;
		logic [COORD_W-1:0] tile_y;
		logic [COORD_W-1:0] tile_w;
		logic [COORD_W-1:0] tile_h;
		logic               last_candidate;
	} cand_t;

	// rank of one candidate; qual low means skipped
	typedef struct packed {
		logic             qual;
		logic [FWD_W-1:0] fwd;
		logic [ACR_W-1:0] acr;
		logic [CTR_W-1:0] ctr;
	} rank_t;

endpackage

`default_nettype wire

### hdl/dts_cand_if.sv
// dts_cand_if: candidate channel, valid/ready with the candidate fields
// depends on dts_pkg for field widths
`default_nettype none

interface dts_cand_if;
	logic                          valid;
	logic                          ready;
	logic [dts_pkg::KEY_W-1:0]     view_key;
	logic signed [dts_pkg::TILE_W-1:0]  tile_number;
	logic signed [dts_pkg::COORD_W-1:0] view_w;
	logic signed [dts_pkg::COORD_W-1:0] view_h;
	logic signed [dts_pkg::COORD_W-1:0] tile_x;
	logic signed [dts_pkg::COORD_W-1:0] tile_y;
	logic signed [dts_pkg::COORD_W-1:0] tile_w;
	logic signed [dts_pkg::COORD_W-1:0] tile_h;
	logic                          last_candidate;

	modport source (
		output valid, view_key, tile_number, view_w, view_h,
		       tile_x, tile_y, tile_w, tile_h, last_candidate,
		input  ready
	);

	modport sink (
		input  valid, view_key, tile_number, view_w, view_h,
		       tile_x, tile_y, tile_w, tile_h, last_candidate,
		output ready
	);
endinterface

`default_nettype wire

### hdl/dts_res_if.sv
// dts_res_if: result channel, valid/ready with found, chosen key and tile
// depends on dts_pkg for field widths
`default_nettype none

interface dts_res_if;
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic [dts_pkg::KEY_W-1:0]         chosen_key;
	logic signed [dts_pkg::TILE_W-1:0] chosen_tile;

	modport source (
		output valid, found, chosen_key, chosen_tile,
		input  ready
	);

	modport sink (
		input  valid, found, chosen_key, chosen_tile,
		output ready
	);
endinterface

`default_nettype wire

### hdl/dts_rank.sv
// dts_rank: qualification and rank (forward gap, across gap, doubled center
// distance) of one candidate against the source rectangle; uses dts_pkg types
`default_nettype none

module dts_rank (
	input  dts_pkg::src_cfg_t cfg,
	input  dts_pkg::cand_t    cand,
	output dts_pkg::rank_t    rank
);

	// 36 bits hold every edge sum and doubled center without wrapping
	localparam int unsigned EXT_W = 36;
	localparam int unsigned PAD_W = EXT_W - dts_pkg::COORD_W;

	logic signed [EXT_W-1:0] t0, tl, s0, sl;   // along the direction
	logic signed [EXT_W-1:0] u0, ul, v0, vl;   // across it (tile u, source v)
	logic signed [EXT_W-1:0] t_end, s_end, u_end, v_end;
	logic signed [EXT_W-1:0] fwd_full, acr_full, ctr_diff, ctr_abs;
	logic                    y_axis, neg_side, side_ok, src_ok, cand_ok;

	function automatic logic is_pos(input logic [dts_pkg::COORD_W-1:0] v);
		return !v[dts_pkg::COORD_W-1] && (|v);
	endfunction

	function automatic logic signed [EXT_W-1:0] sx(input logic [dts_pkg::COORD_W-1:0] v);
		return {{PAD_W{v[dts_pkg::COORD_W-1]}}, v};
	endfunction

	always_comb begin
		y_axis   = cfg.direction[1];
		neg_side = !cfg.direction[0];

		// pick the axis pair for this direction
		t0 = y_axis ? sx(cand.tile_y) : sx(cand.tile_x);
		tl = y_axis ? sx(cand.tile_h) : sx(cand.tile_w);
		s0 = y_axis ? sx(cfg.source_y) : sx(cfg.source_x);
		sl = y_axis ? sx(cfg.source_h) : sx(cfg.source_w);
		u0 = y_axis ? sx(cand.tile_x) : sx(cand.tile_y);
		ul = y_axis ? sx(cand.tile_w) : sx(cand.tile_h);
		v0 = y_axis ? sx(cfg.source_x) : sx(cfg.source_y);
		vl = y_axis ? sx(cfg.source_w) : sx(cfg.source_h);

		t_end = t0 + tl;
		s_end = s0 + sl;
		u_end = u0 + ul;
		v_end = v0 + vl;

		// side check and forward gap; touching edges give a gap of zero
		if (neg_side) begin
			side_ok  = (t_end <= s0);
			fwd_full = s0 - t_end;
		end else begin
			side_ok  = (t0 >= s_end);
			fwd_full = t0 - s_end;
		end

		// across gap between the spans, zero on overlap or touch
		if (v_end < u0)
			acr_full = u0 - v_end;
		else if (u_end < v0)
			acr_full = v0 - u_end;
		else
			acr_full = '0;

		// doubled center distance
		ctr_diff = ((u0 <<< 1) + ul) - ((v0 <<< 1) + vl);
		ctr_abs  = ctr_diff[EXT_W-1] ? -ctr_diff : ctr_diff;

		src_ok  = is_pos(cfg.source_w) && is_pos(cfg.source_h);
		cand_ok = (|cand.view_key) && !cand.tile_number[dts_pkg::TILE_W-1]
			&& is_pos(cand.view_w) && is_pos(cand.view_h)
			&& is_pos(cand.tile_w) && is_pos(cand.tile_h);

		rank.qual = src_ok && cand_ok && side_ok;
		rank.fwd  = fwd_full[dts_pkg::FWD_W-1:0];
		rank.acr  = acr_full[dts_pkg::ACR_W-1:0];
		rank.ctr  = ctr_abs[dts_pkg::CTR_W-1:0];
	end

endmodule

`default_nettype wire

### hdl/directional_tile_select_core.sv
// directional_tile_select_core: top level, keeps the nearest candidate in the
// configured direction; depends on dts_pkg, dts_cand_if, dts_res_if, dts_rank
//
//   channel   dir   handshake         payload
//   cand      in    valid/ready       view_key, tile_number, view/tile geometry,
//                                     last_candidate
//   res       out   valid/ready       found, chosen_key, chosen_tile
//   cfg       in    cfg_we            cfg_index, cfg_data
//
// one candidate per cycle while no last candidate waits on a held result;
// input register, rank stage, then compare against the running best
// the loop that limits the rate is the rank compare against the best register
// arst_n clears configuration, the running best and all valid flags
// a waiting result only holds back a later last candidate; other candidates
// keep flowing into the running best
`default_nettype none

module directional_tile_select_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	dts_cand_if.sink                                cand,
	dts_res_if.source                               res,
	input  wire logic                               cfg_we,
	input  wire logic [dts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [dts_pkg::CFG_DATA_W-1:0]     cfg_data
);

	dts_pkg::src_cfg_t cfg_q;

	logic            s1_v_q;
	dts_pkg::cand_t  cand_s1;
	dts_pkg::rank_t  rank_c;

	logic                          s2_v_q;
	dts_pkg::rank_t                rank_s2;
	logic [dts_pkg::KEY_W-1:0]     key_s2;
	logic [dts_pkg::TILE_W-1:0]    tile_s2;
	logic                          last_s2;

	logic                          have_best_q;
	logic [dts_pkg::KEY_W-1:0]     best_key_q;
	logic [dts_pkg::TILE_W-1:0]    best_tile_q;
	logic [dts_pkg::FWD_W-1:0]     best_fwd_q;
	logic [dts_pkg::ACR_W-1:0]     best_acr_q;
	logic [dts_pkg::CTR_W-1:0]     best_ctr_q;

	logic                          res_v_q;
	logic                          found_q;
	logic [dts_pkg::KEY_W-1:0]     key_q;
	logic [dts_pkg::TILE_W-1:0]    tile_q;

	logic out_free, s2_go, s2_load, s1_move, cand_xfer, better, take, emit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dts_pkg::REG_SOURCE_X:  cfg_q.source_x  <= cfg_data;
				dts_pkg::REG_SOURCE_Y:  cfg_q.source_y  <= cfg_data;
				dts_pkg::REG_SOURCE_W:  cfg_q.source_w  <= cfg_data;
				dts_pkg::REG_SOURCE_H:  cfg_q.source_h  <= cfg_data;
				dts_pkg::REG_DIRECTION: cfg_q.direction <= cfg_data[dts_pkg::DIR_W-1:0];
				default: ;
			endcase
		end
	end

	// stage flow: only a last candidate waits on the result register
	assign out_free  = !res_v_q || res.ready;
	assign s2_go     = s2_v_q && (!last_s2 || out_free);
	assign s2_load   = !s2_v_q || s2_go;
	assign s1_move   = s1_v_q && s2_load;
	assign cand.ready = !s1_v_q || s1_move;
	assign cand_xfer = cand.valid && cand.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (cand.ready) begin
			s1_v_q <= cand.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cand_xfer) begin
			cand_s1.view_key       <= cand.view_key;
			cand_s1.tile_number    <= cand.tile_number;
			cand_s1.view_w         <= cand.view_w;
			cand_s1.view_h         <= cand.view_h;
			cand_s1.tile_x         <= cand.tile_x;
			cand_s1.tile_y         <= cand.tile_y;
			cand_s1.tile_w         <= cand.tile_w;
			cand_s1.tile_h         <= cand.tile_h;
			cand_s1.last_candidate <= cand.last_candidate;
		end
	end

	// rank of the held candidate
	dts_rank u_rank (
		.cfg  (cfg_q),
		.cand (cand_s1),
		.rank (rank_c)
	);

	// rank register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (s2_load) begin
			s2_v_q <= s1_move;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			rank_s2 <= rank_c;
			key_s2  <= cand_s1.view_key;
			tile_s2 <= cand_s1.tile_number;
			last_s2 <= cand_s1.last_candidate;
		end
	end

	// lexicographic compare against the running best; ties keep the best
	always_comb begin
		if (rank_s2.fwd != best_fwd_q)
			better = rank_s2.fwd < best_fwd_q;
		else if (rank_s2.acr != best_acr_q)
			better = rank_s2.acr < best_acr_q;
		else
			better = rank_s2.ctr < best_ctr_q;
	end

	assign take = rank_s2.qual && (!have_best_q || better);
	assign emit = s2_go && last_s2;

	// running best, cleared after each last candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
			best_key_q  <= '0;
			best_tile_q <= '0;
			best_fwd_q  <= '0;
			best_acr_q  <= '0;
			best_ctr_q  <= '0;
		end else if (emit) begin
			have_best_q <= 1'b0;
			best_key_q  <= '0;
			best_tile_q <= '0;
			best_fwd_q  <= '0;
			best_acr_q  <= '0;
			best_ctr_q  <= '0;
		end else if (s2_go && take) begin
			have_best_q <= 1'b1;
			best_key_q  <= key_s2;
			best_tile_q <= tile_s2;
			best_fwd_q  <= rank_s2.fwd;
			best_acr_q  <= rank_s2.acr;
			best_ctr_q  <= rank_s2.ctr;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (emit) begin
			res_v_q <= 1'b1;
		end else if (res.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (take) begin
				found_q <= 1'b1;
				key_q   <= key_s2;
				tile_q  <= tile_s2;
			end else if (have_best_q) begin
				found_q <= 1'b1;
				key_q   <= best_key_q;
				tile_q  <= best_tile_q;
			end else begin
				found_q <= 1'b0;
				key_q   <= '0;
				tile_q  <= dts_pkg::TILE_NONE;
			end
		end
	end

	assign res.valid       = res_v_q;
	assign res.found       = found_q;
	assign res.chosen_key  = key_q;
	assign res.chosen_tile = tile_q;

	// checks on the pipeline and the running best
	a_stall_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v_q && !s2_go) |-> (last_s2 && res_v_q && !res.ready))
		else $error("rank stage stalled without a blocked last candidate");

	a_best_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !have_best_q)
		else $error("running best not cleared after a result");

	a_not_found_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && !found_q) |-> (key_q == '0 && tile_q == dts_pkg::TILE_NONE))
		else $error("not-found result carries a key or tile");

	a_found_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_v_q && found_q) |-> (key_q != '0 && !tile_q[dts_pkg::TILE_W-1]))
		else $error("found result carries a skipped key or negative tile");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!cand.ready |-> (s1_v_q && s2_v_q))
		else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
